// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries concurrent checks.
// No dependencies; pulled in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/cim_pkg.sv =====
// Shared types and constants of the CPU idle and frequency residency monitor.
// No dependencies; imported by every module of the block but cim_fifo.
`default_nettype none

package cim_pkg;

    // Event codes carried in the command field
    localparam logic [1:0] CMD_SWITCH = 2'd0;
    localparam logic [1:0] CMD_FREQ   = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // CPUs addressable by the 3-bit index field
    localparam int CPU_SLOTS = 8;

    // Depth of the request queue and of the result queue
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  cpu_index;
        logic [63:0] timestamp_ns;
        logic        prev_was_idle;
        logic        next_is_idle;
        logic [23:0] new_freq;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  cpu_index_out;
        logic [63:0] idle_time_total;
        logic [63:0] weighted_freq_sum;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hw/rtl/cim_fifo.sv =====
// Small register-based queue with count, used for requests and for results.
// No package dependencies.
`default_nettype none

module cim_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store the entry; no reset on payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cim_front.sv =====
// Front end: accepts events, drops unused commands and out-of-range CPUs,
// and forwards the rest to the request queue. Depends on cim_pkg.
`default_nettype none

module cim_front #(
    parameter int NUM_CPUS = 8
) (
    input  logic              push,
    output logic              full,
    input  cim_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_q_push,
    output cim_pkg::t_in_item o_q_item
);

    import cim_pkg::*;

    logic cmd_ok;
    logic cpu_ok;

    // Classify the command
    always_comb begin
        case (i_item.command) inside
            CMD_SWITCH, CMD_FREQ, CMD_READ: begin
                cmd_ok = 1'b1;
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    assign cpu_ok = (32'(i_item.cpu_index) < NUM_CPUS);

    // Accept whenever the queue has room; forward only meaningful events
    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full && cmd_ok && cpu_ok;
    assign o_q_item = i_item;

endmodule

`default_nettype wire

// ===== hw/rtl/cim_back.sv =====
// Back end: per-CPU state, delta computation, split 64x24 multiply and
// accumulation, in a stalling four-stage pipeline. Depends on cim_pkg.
`default_nettype none

module cim_back #(
    parameter int NUM_CPUS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_valid,
    input  cim_pkg::t_in_item  i_op,
    output logic               o_op_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output cim_pkg::t_out_item o_res
);

    import cim_pkg::*;

    localparam int DEPTH = (NUM_CPUS < CPU_SLOTS) ? NUM_CPUS : CPU_SLOTS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic             valid;
        logic [1:0]       cmd;
        logic [IDX_W-1:0] idx;
        logic [2:0]       cpu;
        logic [63:0]      idle_d;
    } t_tag;

    // Per-CPU state touched in the first stage
    logic [63:0] r_idle_stamp [DEPTH];
    logic        r_running    [DEPTH];
    logic [63:0] r_freq_stamp [DEPTH];
    logic [23:0] r_cur_freq   [DEPTH];
    // Per-CPU accumulators touched in the last stage
    logic [63:0] r_idle_acc   [DEPTH];
    logic [63:0] r_freq_acc   [DEPTH];

    logic             adv;
    logic [IDX_W-1:0] a_idx;
    logic [63:0]      a_idle_diff;
    logic [63:0]      a_freq_diff;
    logic             a_idle_later;
    logic             a_freq_later;
    t_tag             n_a, r_a, r_b, r_c;
    logic [63:0]      n_a_fdelta, r_a_fdelta;
    logic [23:0]      r_a_freq;
    logic [55:0]      n_b_pl, r_b_pl;
    logic [31:0]      n_b_ph, r_b_ph;
    logic [63:0]      n_c_prod, r_c_prod;
    logic [63:0]      d_idle_sum;
    logic [63:0]      d_freq_sum;

    // Stall everything while the result queue is full
    assign adv      = !i_res_full;
    assign o_op_pop = adv && i_op_valid;

    // Stage A: elapsed time against the stamps
    assign a_idx        = i_op.cpu_index[IDX_W-1:0];
    assign a_idle_diff  = i_op.timestamp_ns - r_idle_stamp[a_idx];
    assign a_freq_diff  = i_op.timestamp_ns - r_freq_stamp[a_idx];
    assign a_idle_later = i_op.timestamp_ns > r_idle_stamp[a_idx];
    assign a_freq_later = i_op.timestamp_ns > r_freq_stamp[a_idx];

    always_comb begin
        n_a.valid  = i_op_valid;
        n_a.cmd    = i_op.command;
        n_a.idx    = a_idx;
        n_a.cpu    = i_op.cpu_index;
        n_a.idle_d = '0;
        n_a_fdelta = '0;
        case (i_op.command)
            CMD_SWITCH: begin
                n_a.idle_d = i_op.prev_was_idle ? a_idle_diff : '0;
            end
            CMD_FREQ: begin
                n_a_fdelta = a_freq_diff;
            end
            CMD_READ: begin
                // Project to the given time, clamped at zero
                n_a.idle_d = (!r_running[a_idx] && a_idle_later) ? a_idle_diff : '0;
                n_a_fdelta = a_freq_later ? a_freq_diff : '0;
            end
            default: begin
                n_a.idle_d = '0;
            end
        endcase
    end

    // Stage A state: restamp on switch and frequency change
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_idle_stamp[i] <= '0;
                r_running[i]    <= 1'b0;
                r_freq_stamp[i] <= '0;
                r_cur_freq[i]   <= '0;
            end
        end else if (adv && i_op_valid) begin
            case (i_op.command)
                CMD_SWITCH: begin
                    r_idle_stamp[a_idx] <= i_op.timestamp_ns;
                    r_running[a_idx]    <= !i_op.next_is_idle;
                end
                CMD_FREQ: begin
                    r_freq_stamp[a_idx] <= i_op.timestamp_ns;
                    r_cur_freq[a_idx]   <= i_op.new_freq;
                end
                default: begin
                    r_running[a_idx] <= r_running[a_idx];
                end
            endcase
        end
    end

    // Stage B: two 32x24 partial products; upper one needs only 32 bits
    assign n_b_pl = {24'b0, r_a_fdelta[31:0]} * {32'b0, r_a_freq};
    assign n_b_ph = r_a_fdelta[63:32] * {8'b0, r_a_freq};

    // Stage C: combine partials modulo 2^64
    assign n_c_prod = {8'b0, r_b_pl} + {r_b_ph, 32'b0};

    // Advance the pipeline registers together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_c <= '0;
        end else if (adv) begin
            r_a <= n_a;
            r_b <= r_a;
            r_c <= r_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_fdelta <= n_a_fdelta;
            r_a_freq   <= r_cur_freq[a_idx];
            r_b_pl     <= n_b_pl;
            r_b_ph     <= n_b_ph;
            r_c_prod   <= n_c_prod;
        end
    end

    // Stage D: accumulate or report
    assign d_idle_sum = r_idle_acc[r_c.idx] + r_c.idle_d;
    assign d_freq_sum = r_freq_acc[r_c.idx] + r_c_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_idle_acc[i] <= '0;
                r_freq_acc[i] <= '0;
            end
        end else if (adv && r_c.valid) begin
            case (r_c.cmd)
                CMD_SWITCH: begin
                    r_idle_acc[r_c.idx] <= d_idle_sum;
                end
                CMD_FREQ: begin
                    r_freq_acc[r_c.idx] <= d_freq_sum;
                end
                default: begin
                    r_freq_acc[r_c.idx] <= r_freq_acc[r_c.idx];
                end
            endcase
        end
    end

    assign o_res_push              = adv && r_c.valid && (r_c.cmd == CMD_READ);
    assign o_res.cpu_index_out     = r_c.cpu;
    assign o_res.idle_time_total   = d_idle_sum;
    assign o_res.weighted_freq_sum = d_freq_sum;

endmodule

`default_nettype wire

// ===== hw/rtl/cpu_idle_and_freq_residency_monitor_top.sv =====
// CPU idle residency and frequency-time monitor, top level.
// Instantiates cim_front, cim_fifo (twice) and cim_back; depends on cim_pkg
// and assert_macros.svh.
//
// Takes one event per clock while full is low (task switch, frequency change
// or counter read) and keeps per-CPU idle time and time-weighted frequency
// sums. Events with the unused command code or a CPU index at or above
// NUM_CPUS are taken and dropped. A read passes through the four-entry
// request queue, then a stamp stage, a split 64x24 multiply stage and a
// product-combine stage, with the accumulate-and-report step in front of
// the four-entry result queue. The whole pipeline holds while the result
// queue is full; full rises once the request queue has also filled.
`default_nettype none
`include "assert_macros.svh"

module cpu_idle_and_freq_residency_monitor_top #(
    parameter int NUM_CPUS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  cim_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output cim_pkg::t_out_item o_item
);

    import cim_pkg::*;

    logic      q_push;
    logic      q_full;
    t_in_item  q_item;
    logic      op_pop;
    logic      op_empty;
    t_in_item  op_item;
    logic      res_push;
    logic      res_full;
    t_out_item res_item;

    cim_front #(
        .NUM_CPUS (NUM_CPUS)
    ) u_front (
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_item)
    );

    cim_fifo #(
        .WIDTH ($bits(t_in_item)),
        .DEPTH (Q_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_item),
        .o_full  (q_full),
        .i_pop   (op_pop),
        .o_data  (op_item),
        .o_empty (op_empty)
    );

    cim_back #(
        .NUM_CPUS (NUM_CPUS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!op_empty),
        .i_op       (op_item),
        .o_op_pop   (op_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_item)
    );

    cim_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_item),
        .o_empty (empty)
    );

    // Checks
    `ASSERT_IMPLY(a_req_no_overflow, i_clk, i_rst_n, q_push, !q_full)
    `ASSERT_IMPLY(a_res_no_overflow, i_clk, i_rst_n, res_push, !res_full)
    `ASSERT_IMPLY(a_unused_dropped, i_clk, i_rst_n, push && !full && (i_item.command == CMD_UNUSED), !q_push)
    `ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, !empty && !pop, !empty)

endmodule

`default_nettype wire
